// ===== rtl/iida_pkg.sv =====
package iida_pkg;

	// Operation codes of the func field.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_APPEND = 2'd2;

	// Status codes of a result.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [6:0] LIMIT_RESET = 7'd64;

	// What an accepted transaction does to the array.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_UP,
		KIND_DN
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step_up;
		logic step_dn;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  up_done;
		logic  dn_done;
		logic  out_free;
	} dp_sts_t;

endpackage

// ===== rtl/iida_if.sv =====
interface iida_op_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [5:0]         position;
	logic signed [31:0] value;

	modport source (output valid, func, position, value, input ready);
	modport sink (input valid, func, position, value, output ready);
endinterface

interface iida_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] removed_value;
	logic [1:0]         status;
	logic [6:0]         count;
	logic signed [31:0] total;

	modport source (output valid, removed_value, status, count, total, input ready);
	modport sink (input valid, removed_value, status, count, total, output ready);
endinterface

// ===== rtl/iida_ctrl.sv =====
module iida_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_ready,
	input  iida_pkg::dp_sts_t    sts,
	output iida_pkg::ctrl_cmd_t  cmd
);

	iida_pkg::state_t state_q;
	iida_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iida_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iida_pkg::S_IDLE: begin
				if (op_valid) begin
					unique case (sts.kind)
						iida_pkg::KIND_UP: state_d = iida_pkg::S_SHIFT_UP;
						iida_pkg::KIND_DN: state_d = iida_pkg::S_SHIFT_DN;
						default:           state_d = iida_pkg::S_FINISH;
					endcase
				end
			end
			iida_pkg::S_SHIFT_UP: begin
				if (sts.up_done) state_d = iida_pkg::S_FINISH;
			end
			iida_pkg::S_SHIFT_DN: begin
				if (sts.dn_done) state_d = iida_pkg::S_FINISH;
			end
			iida_pkg::S_FINISH: begin
				if (sts.out_free) state_d = iida_pkg::S_IDLE;
			end
			default: state_d = iida_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		op_ready    = (state_q == iida_pkg::S_IDLE);
		cmd.load    = (state_q == iida_pkg::S_IDLE) && op_valid;
		cmd.step_up = (state_q == iida_pkg::S_SHIFT_UP);
		cmd.step_dn = (state_q == iida_pkg::S_SHIFT_DN);
		cmd.finish  = (state_q == iida_pkg::S_FINISH) && sts.out_free;
	end

endmodule

// ===== rtl/iida_dp.sv =====
module iida_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data,
	input  logic [1:0]          func,
	input  logic [5:0]          position,
	input  logic signed [31:0]  value,
	input  iida_pkg::ctrl_cmd_t cmd,
	output iida_pkg::dp_sts_t   sts,
	output logic                res_valid,
	input  logic                res_ready,
	output logic signed [31:0]  removed_value,
	output logic [1:0]          status,
	output logic [6:0]          count,
	output logic signed [31:0]  total
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]        mem [CAPACITY];
	logic [31:0]        rdata_q;

	logic [6:0]         limit_q;
	logic [CW-1:0]      fill_q;
	logic signed [31:0] sum_q;

	iida_pkg::kind_t    kind_q;
	logic [1:0]         stat_q;
	logic [CW-1:0]      pos_q;
	logic [31:0]        val_q;
	logic [31:0]        removed_q;
	logic [CW-1:0]      cur_q;
	logic               pend_q;
	logic               pend_wr_q;
	logic [CW-1:0]      pend_addr_q;
	logic               out_valid_q;

	logic [31:0]        pos32;
	logic [31:0]        fill32;
	logic [31:0]        lim32;
	iida_pkg::kind_t    kind_d;
	logic [1:0]         stat_d;
	logic [CW-1:0]      target_d;
	logic [CW-1:0]      cur_m1;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               we;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;
	logic [CW-1:0]      fill_new;
	logic signed [31:0] sum_new;

	// Decode of the offered transaction against the current fill and limit.
	always_comb begin
		pos32  = 32'(position);
		fill32 = 32'(fill_q);
		if ({25'd0, limit_q} > 32'(CAPACITY)) begin
			lim32 = 32'(CAPACITY);
		end else begin
			lim32 = {25'd0, limit_q};
		end
		kind_d   = iida_pkg::KIND_NONE;
		stat_d   = iida_pkg::ST_DONE;
		target_d = CW'(position);
		priority if (func == iida_pkg::OP_INSERT) begin
			if (pos32 > fill32) begin
				stat_d = iida_pkg::ST_BAD_INDEX;
			end else if (fill32 >= lim32) begin
				stat_d = iida_pkg::ST_FULL;
			end else begin
				kind_d = iida_pkg::KIND_UP;
			end
		end else if (func == iida_pkg::OP_DELETE) begin
			if (pos32 >= fill32) begin
				stat_d = iida_pkg::ST_BAD_INDEX;
			end else begin
				kind_d = iida_pkg::KIND_DN;
			end
		end else if (func == iida_pkg::OP_APPEND) begin
			// Append is an insert at the end with nothing to move.
			target_d = fill_q;
			if (fill32 >= lim32) begin
				stat_d = iida_pkg::ST_FULL;
			end else begin
				kind_d = iida_pkg::KIND_UP;
			end
		end else begin
			kind_d = iida_pkg::KIND_NONE;
		end
	end

	assign cur_m1 = cur_q - 1'b1;

	always_comb begin
		rd_en   = (cmd.step_up && (cur_q != pos_q)) || (cmd.step_dn && (cur_q != fill_q));
		rd_addr = cmd.step_up ? cur_m1[AW-1:0] : cur_q[AW-1:0];
		we      = 1'b0;
		wr_addr = pend_addr_q[AW-1:0];
		wr_data = rdata_q;
		if (cmd.step_up) begin
			if (pend_q) begin
				we = 1'b1;
			end else if (cur_q == pos_q) begin
				we      = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = val_q;
			end
		end else if (cmd.step_dn) begin
			we = pend_q && pend_wr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Sweep: a read is written back in the next cycle, save the deleted entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= iida_pkg::KIND_NONE;
			pend_q <= 1'b0;
		end else if (cmd.load) begin
			kind_q <= kind_d;
			pend_q <= 1'b0;
		end else if (cmd.step_up || cmd.step_dn) begin
			pend_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stat_q    <= stat_d;
			pos_q     <= target_d;
			val_q     <= value;
			removed_q <= '0;
			cur_q     <= (kind_d == iida_pkg::KIND_UP) ? fill_q : target_d;
		end else if (cmd.step_up) begin
			if (rd_en) begin
				pend_addr_q <= cur_q;
				pend_wr_q   <= 1'b1;
				cur_q       <= cur_m1;
			end
		end else if (cmd.step_dn) begin
			if (pend_q && !pend_wr_q) begin
				removed_q <= rdata_q;
			end
			if (rd_en) begin
				pend_addr_q <= cur_m1;
				pend_wr_q   <= (cur_q != pos_q);
				cur_q       <= cur_q + 1'b1;
			end
		end
	end

	always_comb begin
		fill_new = fill_q;
		sum_new  = sum_q;
		unique case (kind_q)
			iida_pkg::KIND_UP: begin
				fill_new = fill_q + 1'b1;
				sum_new  = sum_q + $signed(val_q);
			end
			iida_pkg::KIND_DN: begin
				fill_new = fill_q - 1'b1;
				sum_new  = sum_q - $signed(removed_q);
			end
			default: begin
				fill_new = fill_q;
				sum_new  = sum_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= iida_pkg::LIMIT_RESET;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.finish) begin
				fill_q      <= fill_new;
				sum_q       <= sum_new;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			removed_value <= $signed(removed_q);
			status        <= stat_q;
			count         <= 7'(fill_new);
			total         <= sum_new;
		end
	end

	assign res_valid    = out_valid_q;
	assign sts.kind     = kind_d;
	assign sts.up_done  = (cur_q == pos_q) && !pend_q;
	assign sts.dn_done  = (cur_q == fill_q) && !pend_q;
	assign sts.out_free = !out_valid_q || res_ready;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_up_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && (kind_q == iida_pkg::KIND_UP) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("insert did not grow the fill count");

	a_dn_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && (kind_q == iida_pkg::KIND_DN) |=>
			sum_q == $past(sum_q - $signed(removed_q)))
		else $error("delete did not take the removed entry off the sum");

	a_up_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_up |-> cur_q >= pos_q)
		else $error("upward sweep passed its target");

endmodule

// ===== rtl/indexed_insert_delete_array.sv =====
// Ordered array of signed 32-bit entries with insert, delete and append.
// Operations arrive on the op channel (func, position, value) and each one
// returns exactly one transaction on the res channel: the removed entry (zero
// unless a delete succeeded), a status (done, bad index, full), the entry count
// and the wrapping sum of all entries. cfg_we/cfg_data set the capacity limit;
// write it only while no operation is in flight.
// The entries live in a single-port-write, single-port-read memory, so an
// insert or delete moves one entry per cycle. An accepted insert, delete or
// append passes a shift state, which moves the entries behind the index (none
// for an append), then the finish state, which loads the result; rejected
// operations and the unused code go straight to the finish state. The next
// operation is accepted after the result is loaded, once back in idle.
// op.ready is high only between operations, so one operation is worked at a
// time; the next one may be accepted while the previous result still waits.
// When res.ready is low the result is held in the output register and the
// block stops before loading the following result.
// Reset clears the count, the sum and the output valid and sets the limit to
// 64; memory contents are not cleared and need no clearing pass.
module indexed_insert_delete_array #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	iida_op_if.sink    op,
	iida_res_if.source res
);

	iida_pkg::ctrl_cmd_t cmd;
	iida_pkg::dp_sts_t   sts;

	iida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op.valid),
		.op_ready (op.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iida_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.func          (op.func),
		.position      (op.position),
		.value         (op.value),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res.valid),
		.res_ready     (res.ready),
		.removed_value (res.removed_value),
		.status        (res.status),
		.count         (res.count),
		.total         (res.total)
	);

endmodule
